/* rtl/core/smer_pkg.sv */
`timescale 1ns / 1ps

package smer_pkg;

  localparam int EPOCH_SECONDS_DEF      = 30;
  localparam int SAMPLE_RATE_HZ_DEF     = 25;
  localparam int BPM_PERIOD_SECONDS_DEF = 30;

  // item kinds
  localparam logic [2:0] KIND_ACCEL    = 3'd0;
  localparam logic [2:0] KIND_INTERVAL = 3'd1;
  localparam logic [2:0] KIND_BPM      = 3'd2;
  localparam logic [2:0] KIND_START    = 3'd3;
  localparam logic [2:0] KIND_END      = 3'd4;

  // record types
  localparam logic [2:0] REC_INTERVAL = 3'd1;
  localparam logic [2:0] REC_BPM      = 3'd2;
  localparam logic [2:0] REC_MOTION   = 3'd3;
  localparam logic [2:0] REC_SESSION  = 3'd4;

  localparam int         VERSION_POS   = 6;
  localparam logic [7:0] VERSION_BITS  = 8'(1 << VERSION_POS);
  localparam logic [7:0] TYPE_MASK     = 8'h07;
  localparam logic [7:0] FLAG_COMPLETE = 8'(1 << 3);
  localparam logic [7:0] FLAG_DROPPED  = 8'(1 << 4);

  localparam logic signed [7:0] QUALITY_UNKNOWN = 8'sh80;
  localparam logic [6:0]        PCT_FULL        = 7'd100;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        time_utc;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [15:0]        event_value;
    logic signed [7:0]  event_quality;
    logic [31:0]        new_session_id;
  } item_t;

  typedef struct packed {
    logic [31:0]       rec_session_id;
    logic [15:0]       rec_sequence;
    logic [31:0]       rec_timestamp;
    logic [15:0]       rec_value;
    logic signed [7:0] rec_quality;
    logic [7:0]        rec_type_flags;
    logic              last;
  } rec_t;

  typedef struct packed {
    logic [1:0] count;
    rec_t       first;
    rec_t       second;
  } rec_pair_t;

endpackage

/* rtl/core/smer_if.sv */
`timescale 1ns / 1ps

interface smer_item_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [31:0]        time_utc;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic [15:0]        event_value;
  logic signed [7:0]  event_quality;
  logic [31:0]        new_session_id;

  modport source (
    output valid, kind, time_utc, accel_x, accel_y, accel_z, event_value, event_quality,
    new_session_id,
    input  ready
  );
  modport sink (
    input  valid, kind, time_utc, accel_x, accel_y, accel_z, event_value, event_quality,
    new_session_id,
    output ready
  );
endinterface

interface smer_rec_if;
  logic              valid;
  logic              ready;
  logic [31:0]       rec_session_id;
  logic [15:0]       rec_sequence;
  logic [31:0]       rec_timestamp;
  logic [15:0]       rec_value;
  logic signed [7:0] rec_quality;
  logic [7:0]        rec_type_flags;
  logic              last;

  modport source (
    output valid, rec_session_id, rec_sequence, rec_timestamp, rec_value, rec_quality,
    rec_type_flags, last,
    input  ready
  );
  modport sink (
    input  valid, rec_session_id, rec_sequence, rec_timestamp, rec_value, rec_quality,
    rec_type_flags, last,
    output ready
  );
endinterface

/* rtl/core/sleep_motion_epoch_recorder_core.sv */
`timescale 1ns / 1ps
// channel  modport  payload                                              transfer
// item     sink     kind, time_utc, accel x/y/z, event value/quality, id  valid && ready
// rec      source   session id, sequence, time, value, quality, flags    valid && ready
//
// one item per cycle unless the record buffer stalls; an item giving two records
// holds the rec port for both; its first record is valid on rec after the 4-stage epoch
// division pipeline, whose last stage feeds the session update into the record buffer
// the record buffer holds one item's records; when full, stall backs up the pipe
// rst is synchronous and clears all session state and valids

module sleep_motion_epoch_recorder_core import smer_pkg::*; #(
  parameter int EPOCH_SECONDS      = EPOCH_SECONDS_DEF,
  parameter int SAMPLE_RATE_HZ     = SAMPLE_RATE_HZ_DEF,
  parameter int BPM_PERIOD_SECONDS = BPM_PERIOD_SECONDS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  smer_item_if.sink  item,
  smer_rec_if.source rec
);

  item_t       in_item;
  item_t       al_item;
  logic        al_valid, al_ready;
  logic [31:0] al_epoch;
  logic        buf_free, buf_load;
  rec_pair_t   pair;

  assign in_item.kind           = item.kind;
  assign in_item.time_utc       = item.time_utc;
  assign in_item.accel_x        = item.accel_x;
  assign in_item.accel_y        = item.accel_y;
  assign in_item.accel_z        = item.accel_z;
  assign in_item.event_value    = item.event_value;
  assign in_item.event_quality  = item.event_quality;
  assign in_item.new_session_id = item.new_session_id;

  smer_epoch_align #(
    .EPOCH_SECONDS(EPOCH_SECONDS)
  ) u_align (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_item   (in_item),
    .out_valid (al_valid),
    .out_ready (al_ready),
    .out_item  (al_item),
    .out_epoch (al_epoch)
  );

  smer_session_ctl #(
    .EPOCH_SECONDS      (EPOCH_SECONDS),
    .SAMPLE_RATE_HZ     (SAMPLE_RATE_HZ),
    .BPM_PERIOD_SECONDS (BPM_PERIOD_SECONDS)
  ) u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (al_valid),
    .in_ready (al_ready),
    .item     (al_item),
    .epoch    (al_epoch),
    .buf_free (buf_free),
    .buf_load (buf_load),
    .pair     (pair)
  );

  smer_rec_buf u_buf (
    .clk  (clk),
    .rst  (rst),
    .load (buf_load),
    .pair (pair),
    .free (buf_free),
    .rec  (rec)
  );

endmodule

/* rtl/core/smer_epoch_align.sv */
`timescale 1ns / 1ps

module smer_epoch_align import smer_pkg::*; #(
  parameter int EPOCH_SECONDS = EPOCH_SECONDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output item_t       out_item,
  output logic [31:0] out_epoch
);

  // floor(t / E) = (t * RECIP) >> DIV_SHIFT, exact for every 32-bit t
  localparam int         EPOCH_LOG  = $clog2(EPOCH_SECONDS);
  localparam int         DIV_SHIFT  = 32 + EPOCH_LOG;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << DIV_SHIFT) + 64'(EPOCH_SECONDS) - 64'd1) / 64'(EPOCH_SECONDS);
  localparam logic [32:0] RECIP      = RECIP_FULL[32:0];
  localparam int         EPOCH_W    = $clog2(EPOCH_SECONDS + 1);

  logic v1, v2, v3, v4;
  logic ld1, ld2, ld3, ld4;
  item_t item1, item2, item3, item4;
  logic [48:0] pp_hi, pp_lo;
  logic [31:0] quot;
  logic [31:0] epoch_base;
  logic [64:0] prod_sum;
  logic [64:0] prod_shr;
  logic [31+EPOCH_W:0] epoch_prod;

  assign ld4 = !v4 || out_ready;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;

  assign prod_sum   = {pp_hi, 16'd0} + {16'd0, pp_lo};
  assign prod_shr   = prod_sum >> DIV_SHIFT;
  assign epoch_prod = quot * EPOCH_W'(EPOCH_SECONDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ld1) v1 <= in_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) item1 <= in_item;
    if (ld2) begin
      item2 <= item1;
      pp_hi <= item1.time_utc[31:16] * RECIP;
      pp_lo <= item1.time_utc[15:0] * RECIP;
    end
    if (ld3) begin
      item3 <= item2;
      quot  <= prod_shr[31:0];
    end
    if (ld4) begin
      item4      <= item3;
      epoch_base <= epoch_prod[31:0];
    end
  end

  assign in_ready  = ld1;
  assign out_valid = v4;
  assign out_item  = item4;
  assign out_epoch = epoch_base;

endmodule

/* rtl/core/smer_session_ctl.sv */
`timescale 1ns / 1ps

module smer_session_ctl import smer_pkg::*; #(
  parameter int EPOCH_SECONDS      = EPOCH_SECONDS_DEF,
  parameter int SAMPLE_RATE_HZ     = SAMPLE_RATE_HZ_DEF,
  parameter int BPM_PERIOD_SECONDS = BPM_PERIOD_SECONDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       item,
  input  logic [31:0] epoch,
  input  logic        buf_free,
  output logic        buf_load,
  output rec_pair_t   pair
);

  // samples*100 / (E*SR) by one constant multiply, exact for 23-bit numerators
  localparam int          PCT_DIV   = EPOCH_SECONDS * SAMPLE_RATE_HZ;
  localparam int          PCT_LOG   = $clog2(PCT_DIV);
  localparam int          PCT_SHIFT = 23 + PCT_LOG;
  localparam logic [63:0] PCT_RECIP =
    ((64'd1 << PCT_SHIFT) + 64'(PCT_DIV) - 64'd1) / 64'(PCT_DIV);
  localparam logic [30:0] PCT_MULT  = 31'(PCT_RECIP * 64'd100);

  logic               capture_active, capture_active_next;
  logic [31:0]        session_ident, session_ident_next;
  logic [16:0]        next_seq, next_seq_next;
  logic [15:0]        drop_count, drop_count_next;
  logic               sequence_exhausted, sequence_exhausted_next;
  logic [31:0]        last_bpm_time, last_bpm_time_next;
  logic [31:0]        epoch_origin, epoch_origin_next;
  logic [15:0]        epoch_energy, epoch_energy_next;
  logic [15:0]        epoch_samples, epoch_samples_next;
  logic signed [15:0] prev_sample [3];
  logic signed [15:0] prev_sample_next [3];
  logic               prev_sample_valid, prev_sample_valid_next;

  logic        fire;
  logic        epoch_change;
  logic [18:0] motion_sum;
  logic [15:0] energy_base, energy_new, samples_base, samples_new;
  logic [16:0] energy_add;
  logic [46:0] pct_prod, pct_shr;
  logic [6:0]  pct;
  logic        bpm_ok;
  logic [31:0] session_new;

  logic              log_req, log_emit, log_drop;
  logic [2:0]        log_type;
  logic [31:0]       log_ts;
  logic [15:0]       log_val;
  logic signed [7:0] log_q;
  logic [15:0]       drop_after;
  logic [16:0]       seq_after;
  logic              start_take, end_take;
  rec_t              log_rec, term_rec, start_rec;

  function automatic logic [16:0] abs_diff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
    logic signed [16:0] d;
    d = $signed({a[15], a}) - $signed({b[15], b});
    return d[16] ? 17'(-d) : 17'(d);
  endfunction

  function automatic logic [7:0] flags_of(input logic [2:0] rtype);
    return VERSION_BITS | (TYPE_MASK & {5'd0, rtype});
  endfunction

  assign fire     = in_valid && buf_free;
  assign in_ready = buf_free;
  assign buf_load = fire;

  assign epoch_change = epoch != epoch_origin;
  assign motion_sum   = {2'd0, abs_diff(item.accel_x, prev_sample[0])}
                      + {2'd0, abs_diff(item.accel_y, prev_sample[1])}
                      + {2'd0, abs_diff(item.accel_z, prev_sample[2])};
  assign energy_base  = epoch_change ? 16'd0 : epoch_energy;
  assign energy_add   = {1'b0, energy_base} + {1'b0, motion_sum[18:3]};
  assign energy_new   = !prev_sample_valid ? energy_base :
                        (energy_add[16] ? 16'hFFFF : energy_add[15:0]);
  assign samples_base = epoch_change ? 16'd0 : epoch_samples;
  assign samples_new  = (samples_base == 16'hFFFF) ? samples_base : samples_base + 16'd1;

  assign pct_prod = epoch_samples * PCT_MULT;
  assign pct_shr  = pct_prod >> PCT_SHIFT;
  assign pct      = (pct_shr >= 47'd100) ? PCT_FULL : pct_shr[6:0];

  // plain 33-bit compare: the difference is not wrapped
  assign bpm_ok = {1'b0, item.time_utc} >= ({1'b0, last_bpm_time} + 33'(BPM_PERIOD_SECONDS));

  assign session_new = (item.new_session_id != 32'd0) ? item.new_session_id :
                       ((item.time_utc != 32'd0) ? item.time_utc : 32'd1);

  always_comb begin
    log_req  = 1'b0;
    log_type = REC_MOTION;
    log_ts   = epoch_origin;
    log_val  = epoch_energy;
    log_q    = $signed({1'b0, pct});
    if (capture_active) begin
      unique case (item.kind)
        KIND_ACCEL: log_req = epoch_change && (epoch_samples != 16'd0);
        KIND_INTERVAL: begin
          log_req  = item.event_value != 16'd0;
          log_type = REC_INTERVAL;
          log_ts   = item.time_utc;
          log_val  = item.event_value;
          log_q    = item.event_quality;
        end
        KIND_BPM: begin
          log_req  = bpm_ok;
          log_type = REC_BPM;
          log_ts   = item.time_utc;
          log_val  = item.event_value;
          log_q    = item.event_quality;
        end
        KIND_END: log_req = epoch_samples != 16'd0;
        default: log_req = 1'b0;
      endcase
    end
  end

  assign log_emit   = log_req && !sequence_exhausted && !next_seq[16];
  assign log_drop   = log_req && !log_emit;
  assign drop_after = (log_drop && drop_count != 16'hFFFF) ? drop_count + 16'd1 : drop_count;
  assign seq_after  = log_emit ? next_seq + 17'd1 : next_seq;
  assign start_take = (item.kind == KIND_START) && !capture_active;
  assign end_take   = (item.kind == KIND_END) && capture_active;

  always_comb begin
    log_rec.rec_session_id = session_ident;
    log_rec.rec_sequence   = next_seq[15:0];
    log_rec.rec_timestamp  = log_ts;
    log_rec.rec_value      = log_val;
    log_rec.rec_quality    = log_q;
    log_rec.rec_type_flags = flags_of(log_type);
    log_rec.last           = item.kind != KIND_END;

    term_rec.rec_session_id = session_ident;
    term_rec.rec_sequence   = seq_after[15:0];
    term_rec.rec_timestamp  = item.time_utc;
    term_rec.rec_value      = drop_after;
    term_rec.rec_quality    = QUALITY_UNKNOWN;
    term_rec.rec_type_flags = flags_of(REC_SESSION) | FLAG_COMPLETE
                            | ((drop_after != 16'd0) ? FLAG_DROPPED : 8'd0);
    term_rec.last           = 1'b1;

    start_rec.rec_session_id = session_new;
    start_rec.rec_sequence   = 16'd0;
    start_rec.rec_timestamp  = item.time_utc;
    start_rec.rec_value      = 16'd0;
    start_rec.rec_quality    = QUALITY_UNKNOWN;
    start_rec.rec_type_flags = flags_of(REC_SESSION);
    start_rec.last           = 1'b1;

    pair.count  = 2'd0;
    pair.first  = log_rec;
    pair.second = term_rec;
    if (start_take) begin
      pair.count = 2'd1;
      pair.first = start_rec;
    end else if (end_take) begin
      if (log_emit) begin
        pair.count = 2'd2;
      end else begin
        pair.count = 2'd1;
        pair.first = term_rec;
      end
    end else if (log_emit) begin
      pair.count = 2'd1;
    end
  end

  always_comb begin
    capture_active_next     = capture_active;
    session_ident_next      = session_ident;
    next_seq_next           = next_seq;
    drop_count_next         = drop_count;
    sequence_exhausted_next = sequence_exhausted;
    last_bpm_time_next      = last_bpm_time;
    epoch_origin_next       = epoch_origin;
    epoch_energy_next       = epoch_energy;
    epoch_samples_next      = epoch_samples;
    prev_sample_next        = prev_sample;
    prev_sample_valid_next  = prev_sample_valid;

    if (capture_active && item.kind != KIND_START) begin
      next_seq_next           = seq_after;
      drop_count_next         = drop_after;
      sequence_exhausted_next = sequence_exhausted || log_drop;
      if (item.kind == KIND_ACCEL) begin
        epoch_origin_next      = epoch;
        epoch_energy_next      = energy_new;
        epoch_samples_next     = samples_new;
        prev_sample_next[0]    = item.accel_x;
        prev_sample_next[1]    = item.accel_y;
        prev_sample_next[2]    = item.accel_z;
        prev_sample_valid_next = 1'b1;
      end
      if (item.kind == KIND_BPM && log_emit) last_bpm_time_next = item.time_utc;
    end

    // a new session and the end of one both start from a clean slate
    if (start_take || end_take) begin
      capture_active_next     = 1'b0;
      session_ident_next      = 32'd0;
      next_seq_next           = 17'd0;
      drop_count_next         = 16'd0;
      sequence_exhausted_next = 1'b0;
      last_bpm_time_next      = 32'd0;
      epoch_origin_next       = 32'd0;
      epoch_energy_next       = 16'd0;
      epoch_samples_next      = 16'd0;
      prev_sample_next[0]     = 16'sd0;
      prev_sample_next[1]     = 16'sd0;
      prev_sample_next[2]     = 16'sd0;
      prev_sample_valid_next  = 1'b0;
    end
    if (start_take) begin
      capture_active_next = 1'b1;
      session_ident_next  = session_new;
      next_seq_next       = 17'd1;
      epoch_origin_next   = epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_active     <= 1'b0;
      session_ident      <= 32'd0;
      next_seq           <= 17'd0;
      drop_count         <= 16'd0;
      sequence_exhausted <= 1'b0;
      last_bpm_time      <= 32'd0;
      epoch_origin       <= 32'd0;
      epoch_energy       <= 16'd0;
      epoch_samples      <= 16'd0;
      prev_sample[0]     <= 16'sd0;
      prev_sample[1]     <= 16'sd0;
      prev_sample[2]     <= 16'sd0;
      prev_sample_valid  <= 1'b0;
    end else if (fire) begin
      capture_active     <= capture_active_next;
      session_ident      <= session_ident_next;
      next_seq           <= next_seq_next;
      drop_count         <= drop_count_next;
      sequence_exhausted <= sequence_exhausted_next;
      last_bpm_time      <= last_bpm_time_next;
      epoch_origin       <= epoch_origin_next;
      epoch_energy       <= epoch_energy_next;
      epoch_samples      <= epoch_samples_next;
      prev_sample        <= prev_sample_next;
      prev_sample_valid  <= prev_sample_valid_next;
    end
  end

  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    fire && item.kind == KIND_START && !capture_active
    |=> capture_active && next_seq == 17'd1 && session_ident != 32'd0)
    else $error("start did not open a session");

  a_exhausted_seq: assert property (@(posedge clk) disable iff (rst)
    sequence_exhausted |-> next_seq[16])
    else $error("exhausted without a full sequence space");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !capture_active |-> next_seq == 17'd0 && drop_count == 16'd0)
    else $error("counters not cleared while idle");

endmodule

/* rtl/core/smer_rec_buf.sv */
`timescale 1ns / 1ps

module smer_rec_buf import smer_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  rec_pair_t  pair,
  output logic       free,
  smer_rec_if.source rec
);

  logic [1:0] count;
  rec_t       first;
  rec_t       second;
  logic       pop;

  assign pop  = rec.valid && rec.ready;
  assign free = (count == 2'd0) || (count == 2'd1 && rec.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= pair.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      first  <= pair.first;
      second <= pair.second;
    end else if (pop && count == 2'd2) begin
      first <= second;
    end
  end

  assign rec.valid          = count != 2'd0;
  assign rec.rec_session_id = first.rec_session_id;
  assign rec.rec_sequence   = first.rec_sequence;
  assign rec.rec_timestamp  = first.rec_timestamp;
  assign rec.rec_value      = first.rec_value;
  assign rec.rec_quality    = first.rec_quality;
  assign rec.rec_type_flags = first.rec_type_flags;
  assign rec.last           = first.last;

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !first.last && second.last)
    else $error("two-record pair with wrong last marking");

endmodule

/* tb/sv/tb_sleep_motion_epoch_recorder_core.sv */
`timescale 1ns / 1ps

module tb_sleep_motion_epoch_recorder_core;
  import smer_pkg::*;

  localparam int EPOCH_LEN    = EPOCH_SECONDS_DEF;
  localparam int EPOCH_FULL   = EPOCH_SECONDS_DEF * SAMPLE_RATE_HZ_DEF;
  localparam int BPM_GAP      = BPM_PERIOD_SECONDS_DEF;
  localparam int CYCLE_LIMIT  = 100_000;
  localparam int LONG_SAMPLES = 760;
  localparam int RANDOM_ITEMS = 840;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  smer_item_if item_ch ();
  smer_rec_if  rec_ch ();

  sleep_motion_epoch_recorder_core u_top (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .rec  (rec_ch)
  );

  int cycle_count    = 0;
  int mismatches     = 0;
  int items_sent     = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  // session state mirrored from the block
  logic               sess_active;
  logic [31:0]        sess_id;
  logic [16:0]        sess_next_seq;
  logic [15:0]        sess_drops;
  logic               sess_seq_spent;
  logic [31:0]        sess_bpm_time;
  logic [31:0]        sess_epoch_origin;
  logic [15:0]        sess_energy;
  logic [15:0]        sess_samples;
  logic signed [15:0] sess_prev [0:2];
  logic               sess_prev_ok;

  rec_t pending_records[$];

  typedef struct packed {
    item_t it;
    logic  from_model;
    logic  has_rec;
    rec_t  rec;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic logic [7:0] flags_for(logic [2:0] typ);
    return VERSION_BITS | (8'(typ) & TYPE_MASK);
  endfunction

  function automatic item_t mk_item(logic [2:0] kind, logic [31:0] t, logic [15:0] ax,
                                    logic [15:0] ay, logic [15:0] az, logic [15:0] val,
                                    logic [7:0] qual, logic [31:0] sid);
    item_t it;
    it.kind           = kind;
    it.time_utc       = t;
    it.accel_x        = ax;
    it.accel_y        = ay;
    it.accel_z        = az;
    it.event_value    = val;
    it.event_quality  = qual;
    it.new_session_id = sid;
    return it;
  endfunction

  function automatic rec_t mk_rec(logic [31:0] id, logic [15:0] seq, logic [31:0] ts,
                                  logic [15:0] val, logic [7:0] qual, logic [7:0] tf,
                                  logic fin);
    rec_t r;
    r.rec_session_id = id;
    r.rec_sequence   = seq;
    r.rec_timestamp  = ts;
    r.rec_value      = val;
    r.rec_quality    = qual;
    r.rec_type_flags = tf;
    r.last           = fin;
    return r;
  endfunction

  function automatic void expect_none(item_t it);
    stim_row_t row;
    row.it         = it;
    row.from_model = 1'b0;
    row.has_rec    = 1'b0;
    row.rec        = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void expect_one(item_t it, rec_t r);
    stim_row_t row;
    row.it         = it;
    row.from_model = 1'b0;
    row.has_rec    = 1'b1;
    row.rec        = r;
    directed_rows.push_back(row);
  endfunction

  function automatic void expect_model(item_t it);
    stim_row_t row;
    row.it         = it;
    row.from_model = 1'b1;
    row.has_rec    = 1'b0;
    row.rec        = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void clear_session();
    sess_active       = 1'b0;
    sess_id           = '0;
    sess_next_seq     = '0;
    sess_drops        = '0;
    sess_seq_spent    = 1'b0;
    sess_bpm_time     = '0;
    sess_epoch_origin = '0;
    sess_energy       = '0;
    sess_samples      = '0;
    sess_prev[0]      = '0;
    sess_prev[1]      = '0;
    sess_prev[2]      = '0;
    sess_prev_ok      = 1'b0;
  endfunction

  function automatic void count_drop();
    if (sess_drops != 16'hFFFF) sess_drops++;
  endfunction

  function automatic void emit(logic [15:0] seq, logic [31:0] ts, logic [15:0] val,
                               logic [7:0] qual, logic [7:0] tf);
    pending_records.push_back(mk_rec(sess_id, seq, ts, val, qual, tf, 1'b0));
  endfunction

  function automatic logic log_record(logic [2:0] typ, logic [31:0] ts, logic [15:0] val,
                                      logic [7:0] qual);
    if (!sess_active) return 1'b0;
    if (sess_seq_spent && typ != REC_SESSION) begin
      count_drop();
      return 1'b0;
    end
    if (sess_next_seq > 17'h0FFFF) begin
      count_drop();
      sess_seq_spent = 1'b1;
      return 1'b0;
    end
    emit(sess_next_seq[15:0], ts, val, qual, flags_for(typ));
    sess_next_seq++;
    return 1'b1;
  endfunction

  function automatic void flush_epoch();
    int unsigned pct;
    if (!sess_active || sess_samples == 0) return;
    pct = 32'(sess_samples) * 100 / EPOCH_FULL;
    if (pct > 100) pct = 100;
    void'(log_record(REC_MOTION, sess_epoch_origin, sess_energy, 8'(pct)));
  endfunction

  // records that the block owes for one accepted item
  function automatic void frame_records(item_t it);
    int                 n_before;
    logic [31:0]        ep;
    int                 d;
    int                 e;
    logic signed [15:0] smp [0:2];
    logic signed [63:0] bpm_age;
    rec_t               tail;
    n_before = pending_records.size();
    ep = it.time_utc - it.time_utc % 32'(EPOCH_LEN);
    if (it.kind == KIND_START) begin
      if (!sess_active) begin
        clear_session();
        sess_active = 1'b1;
        sess_id = (it.new_session_id != 0) ? it.new_session_id :
                  (it.time_utc != 0) ? it.time_utc : 32'd1;
        sess_epoch_origin = ep;
        void'(log_record(REC_SESSION, it.time_utc, 16'd0, QUALITY_UNKNOWN));
      end
    end else if (sess_active) begin
      case (it.kind)
        KIND_ACCEL: begin
          smp[0] = it.accel_x;
          smp[1] = it.accel_y;
          smp[2] = it.accel_z;
          if (ep != sess_epoch_origin) begin
            flush_epoch();
            sess_epoch_origin = ep;
            sess_energy       = '0;
            sess_samples      = '0;
          end
          if (sess_prev_ok) begin
            e = 0;
            for (int k = 0; k < 3; k++) begin
              d = int'(smp[k]) - int'(sess_prev[k]);
              e += (d < 0) ? -d : d;
            end
            e = (e >> 3) + int'(sess_energy);
            sess_energy = (e > 65535) ? 16'hFFFF : 16'(e);
          end
          for (int k = 0; k < 3; k++) sess_prev[k] = smp[k];
          sess_prev_ok = 1'b1;
          if (sess_samples != 16'hFFFF) sess_samples++;
        end
        KIND_INTERVAL: begin
          if (it.event_value != 0)
            void'(log_record(REC_INTERVAL, it.time_utc, it.event_value, it.event_quality));
        end
        KIND_BPM: begin
          bpm_age = $signed({32'd0, it.time_utc}) - $signed({32'd0, sess_bpm_time});
          if (bpm_age >= BPM_GAP) begin
            if (log_record(REC_BPM, it.time_utc, it.event_value, it.event_quality))
              sess_bpm_time = it.time_utc;
          end
        end
        KIND_END: begin
          flush_epoch();
          emit(sess_next_seq[15:0], it.time_utc, sess_drops, QUALITY_UNKNOWN,
               flags_for(REC_SESSION) | FLAG_COMPLETE |
               ((sess_drops != 0) ? FLAG_DROPPED : 8'h00));
          clear_session();
        end
        default: ;
      endcase
    end
    if (pending_records.size() > n_before) begin
      tail = pending_records.pop_back();
      tail.last = 1'b1;
      pending_records.push_back(tail);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got 0x%0h, expected 0x%0h (cycle %0d)",
             what, got, want, cycle_count);
  endtask

  task automatic drive_item(input item_t it);
    int gap;
    gap = 0;
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.kind           <= it.kind;
    item_ch.time_utc       <= it.time_utc;
    item_ch.accel_x        <= it.accel_x;
    item_ch.accel_y        <= it.accel_y;
    item_ch.accel_z        <= it.accel_z;
    item_ch.event_value    <= it.event_value;
    item_ch.event_quality  <= it.event_quality;
    item_ch.new_session_id <= it.new_session_id;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic push_item(input item_t it);
    drive_item(it);
    frame_records(it);
    items_sent++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // record sink: checks each transfer, then picks the next ready
  initial begin
    rec_t want;
    rec_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rec_ch.valid && rec_ch.ready) begin
        if (pending_records.size() == 0) begin
          report_mismatch("record with none pending, sequence",
                          32'(rec_ch.rec_sequence), '0);
        end else begin
          want = pending_records.pop_front();
          if (rec_ch.rec_session_id !== want.rec_session_id)
            report_mismatch("rec_session_id", rec_ch.rec_session_id, want.rec_session_id);
          if (rec_ch.rec_sequence !== want.rec_sequence)
            report_mismatch("rec_sequence", 32'(rec_ch.rec_sequence),
                            32'(want.rec_sequence));
          if (rec_ch.rec_timestamp !== want.rec_timestamp)
            report_mismatch("rec_timestamp", rec_ch.rec_timestamp, want.rec_timestamp);
          if (rec_ch.rec_value !== want.rec_value)
            report_mismatch("rec_value", 32'(rec_ch.rec_value), 32'(want.rec_value));
          if (rec_ch.rec_quality !== want.rec_quality)
            report_mismatch("rec_quality", 32'(rec_ch.rec_quality[7:0]),
                            32'(want.rec_quality[7:0]));
          if (rec_ch.rec_type_flags !== want.rec_type_flags)
            report_mismatch("rec_type_flags", 32'(rec_ch.rec_type_flags),
                            32'(want.rec_type_flags));
          if (rec_ch.last !== want.last)
            report_mismatch("last", 32'(rec_ch.last), 32'(want.last));
        end
      end
      rec_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  initial begin
    int          n0;
    int          pick;
    int          phase_end;
    logic [2:0]  kind;
    logic [31:0] t;
    logic [31:0] sid;
    logic [15:0] val;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;

    item_ch.valid          = 1'b0;
    item_ch.kind           = KIND_ACCEL;
    item_ch.time_utc       = '0;
    item_ch.accel_x        = '0;
    item_ch.accel_y        = '0;
    item_ch.accel_z        = '0;
    item_ch.event_value    = '0;
    item_ch.event_quality  = '0;
    item_ch.new_session_id = '0;
    clear_session();
    ax = '0;
    ay = '0;
    az = '0;

    expect_none(mk_item(KIND_INTERVAL, 32'd5, 16'd0, 16'd0, 16'd0, 16'd7, 8'd1, 32'd0));
    // zero id and zero time give session id 1
    expect_one(mk_item(KIND_START, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 32'd0),
               mk_rec(32'd1, 16'd0, 32'd0, 16'd0, QUALITY_UNKNOWN,
                      flags_for(REC_SESSION), 1'b1));
    expect_none(mk_item(KIND_START, 32'd40, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 32'd99));
    // full-scale swings saturate the epoch energy
    expect_none(mk_item(KIND_ACCEL, 32'd0, 16'h8000, 16'h8000, 16'h8000, 16'd0, 8'd0, 32'd0));
    expect_none(mk_item(KIND_ACCEL, 32'd5, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0, 8'd0, 32'd0));
    expect_none(mk_item(KIND_ACCEL, 32'd10, 16'h8000, 16'h8000, 16'h8000, 16'd0, 8'd0, 32'd0));
    expect_none(mk_item(KIND_ACCEL, 32'd15, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0, 8'd0, 32'd0));
    // epoch starting at time zero is still flushed
    expect_one(mk_item(KIND_ACCEL, 32'd30, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 32'd0),
               mk_rec(32'd1, 16'd1, 32'd0, 16'hFFFF, 8'd0, flags_for(REC_MOTION), 1'b1));
    expect_none(mk_item(KIND_INTERVAL, 32'd31, 16'd0, 16'd0, 16'd0, 16'd0, 8'h7F, 32'd0));
    expect_one(mk_item(KIND_INTERVAL, 32'd31, 16'd0, 16'd0, 16'd0, 16'hFFFF, 8'h7F, 32'd0),
               mk_rec(32'd1, 16'd2, 32'd31, 16'hFFFF, 8'h7F, flags_for(REC_INTERVAL), 1'b1));
    expect_model(mk_item(KIND_INTERVAL, 32'd32, 16'd0, 16'd0, 16'd0, 16'd1, 8'h80, 32'd0));
    expect_model(mk_item(KIND_BPM, 32'd33, 16'd0, 16'd0, 16'd0, 16'd60, 8'd5, 32'd0));
    // bpm rate limit: one second short, then exactly on the period
    expect_none(mk_item(KIND_BPM, 32'd62, 16'd0, 16'd0, 16'd0, 16'd61, 8'd5, 32'd0));
    expect_model(mk_item(KIND_BPM, 32'd63, 16'd0, 16'd0, 16'd0, 16'd0, 8'hFF, 32'd0));
    expect_none(mk_item(KIND_BPM, 32'd0, 16'd0, 16'd0, 16'd0, 16'd70, 8'd5, 32'd0));
    expect_none(mk_item(3'(int'(KIND_END) + 3), 32'd64, 16'd0, 16'd0, 16'd0, 16'd9, 8'd1,
                        32'd5));
    expect_model(mk_item(KIND_END, 32'd100, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 32'd0));
    expect_none(mk_item(KIND_ACCEL, 32'd101, 16'd1, 16'd2, 16'd3, 16'd0, 8'd0, 32'd0));
    expect_none(mk_item(KIND_END, 32'd102, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 32'd0));
    expect_model(mk_item(KIND_START, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 32'd0));
    expect_none(mk_item(KIND_ACCEL, 32'hFFFF_FFFF, 16'd1, 16'd0, 16'd0, 16'd0, 8'd0, 32'd0));
    expect_model(mk_item(KIND_BPM, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF, 8'h7F,
                         32'd0));
    expect_model(mk_item(KIND_END, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 32'd0));
    expect_model(mk_item(KIND_START, 32'd12345, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 32'd0));
    expect_model(mk_item(KIND_END, 32'd12345, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 32'd0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      drive_item(directed_rows[i].it);
      n0 = pending_records.size();
      frame_records(directed_rows[i].it);
      if (!directed_rows[i].from_model) begin
        while (pending_records.size() > n0) void'(pending_records.pop_back());
        if (directed_rows[i].has_rec) pending_records.push_back(directed_rows[i].rec);
      end
      items_sent++;
    end

    // one long session: more samples in one epoch than it expects, so the
    // completeness clamps at 100 when the epoch is flushed
    t = 32'($urandom_range(0, 32'h7FFF_0000));
    push_item(mk_item(KIND_START, t, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, $urandom | 32'd1));
    repeat (LONG_SAMPLES) begin
      push_item(mk_item(KIND_ACCEL, t, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 8'($urandom), $urandom));
    end
    t += 32'(EPOCH_LEN);
    repeat (20) begin
      t += 32'($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      if (pick < 20) kind = KIND_ACCEL;
      else if (pick < 40) kind = KIND_BPM;
      else kind = KIND_INTERVAL;
      push_item(mk_item(kind, t, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom_range(1, 65535)), 8'($urandom), $urandom));
    end
    push_item(mk_item(KIND_END, t + 32'd1, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 32'd0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 54;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 54;
        end
        default: begin
          src_idle_pct   = 11;
          sink_stall_pct = 11;
        end
      endcase
      phase_end = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < phase_end) begin
        // stray items with no session open
        repeat ($urandom_range(0, 3)) begin
          kind = 3'($urandom_range(0, 7));
          if (kind == KIND_START) kind = KIND_END;
          push_item(mk_item(kind, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 8'($urandom), $urandom));
        end
        case ($urandom_range(0, 3))
          0: t = 32'd0;
          1: t = 32'hFFFF_FFFF - 32'($urandom_range(0, 200));
          default: t = $urandom;
        endcase
        sid = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom;
        push_item(mk_item(KIND_START, t, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 8'($urandom), sid));
        repeat ($urandom_range(0, 40)) begin
          // time mostly creeps forward, with the odd jump anywhere
          if ($urandom_range(0, 49) == 0) t = $urandom;
          else if ($urandom_range(0, 9) == 0) t += 32'($urandom_range(0, 120));
          else t += 32'($urandom_range(0, 3));
          if ($urandom_range(0, 7) == 0) begin
            ax = 16'($urandom);
            ay = 16'($urandom);
            az = 16'($urandom);
          end else begin
            ax = ax + 16'($urandom_range(0, 400)) - 16'd200;
            ay = ay + 16'($urandom_range(0, 400)) - 16'd200;
            az = az + 16'($urandom_range(0, 400)) - 16'd200;
          end
          pick = $urandom_range(0, 99);
          if (pick < 45) kind = KIND_ACCEL;
          else if (pick < 70) kind = KIND_INTERVAL;
          else if (pick < 88) kind = KIND_BPM;
          else if (pick < 94) kind = 3'($urandom_range(int'(KIND_END) + 1, 7)); // undefined
          else kind = KIND_START;
          case ($urandom_range(0, 9))
            0: val = 16'd0;
            1: val = 16'($urandom);
            default: val = 16'($urandom_range(250, 2000));
          endcase
          push_item(mk_item(kind, t, ax, ay, az, val, 8'($urandom), $urandom));
        end
        push_item(mk_item(KIND_END, t + 32'($urandom_range(0, 60)), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                          $urandom));
      end
    end

    item_ch.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sleep_motion_epoch_recorder_core.f */
rtl/core/smer_pkg.sv
rtl/core/smer_if.sv
rtl/core/smer_epoch_align.sv
rtl/core/smer_session_ctl.sv
rtl/core/smer_rec_buf.sv
rtl/core/sleep_motion_epoch_recorder_core.sv
tb/sv/tb_sleep_motion_epoch_recorder_core.sv
